FILE: design/brb_pkg.sv
// Package for the batched SPSC ring buffer: sizes, operation and status codes,
// transaction structs, controller states and controller/datapath interface structs.
// No dependencies.
`default_nettype none

package brb_pkg;

    localparam int DEPTH       = 1024;
    localparam int ENTRY_BYTES = 8;
    localparam int POS_W       = $clog2(DEPTH);
    localparam int LEN_W       = 10;
    localparam int OCC_W       = 10;
    localparam int DATA_W      = 64;
    localparam int NB_W        = 4;
    localparam int LANE_W      = 8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_RDONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] write_data;
        logic [NB_W-1:0]   write_bytes;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] read_data;
        logic [OCC_W-1:0]  occupancy;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic rd_hit;
    } t_sts;

endpackage

`default_nettype wire

FILE: design/brb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/brb_ctrl.sv
// Controller state machine for the batched SPSC ring buffer.
// Depends on brb_pkg.
`default_nettype none

module brb_ctrl import brb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.rd_hit ? S_RDWAIT : S_IDLE;
            end
            S_RDWAIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_EXEC: begin
                o_cmd.exec   = 1'b1;
                o_cmd.finish = !i_sts.rd_hit;
            end
            S_RDWAIT: begin
                o_cmd.capture_rd = 1'b1;
                o_cmd.finish     = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/brb_datapath.sv
// Datapath: position registers, batch counters, byte-lane entry store and result register.
// Depends on brb_pkg and brb_ram.
`default_nettype none

module brb_datapath import brb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in              i_cmd,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    input  wire t_cmd             i_ctl,
    output t_sts                  o_sts,
    output t_out                  o_result,
    output logic                  o_valid
);

    localparam logic [NB_W-1:0] NB_MAX = NB_W'(ENTRY_BYTES);

    t_in              r_cmd;
    logic [POS_W-1:0] r_prp, r_pwp, r_nrp, r_nwp, r_crp, r_cwp;
    logic [POS_W-1:0] n_prp, n_pwp, n_nrp, n_nwp, n_crp, n_cwp;
    logic [LEN_W-1:0] r_rcnt, r_wcnt, n_rcnt, n_wcnt;
    logic [LEN_W-1:0] r_batch;
    logic             r_wrapped, n_wrapped;
    t_out             r_res;
    logic             r_valid;

    logic [POS_W-1:0] w_nxt;
    logic [POS_W-1:0] w_rd_nxt;
    logic             w_full, w_empty, w_wr_ok, w_rd_ok;
    logic [LEN_W-1:0] w_wcnt_inc, w_rcnt_inc;
    logic [NB_W-1:0]  w_nb;
    t_status          w_status;
    logic [POS_W:0]   w_occ;
    logic [ENTRY_BYTES*LANE_W-1:0] w_rdata;

    function automatic logic [POS_W-1:0] f_adv(input logic [POS_W-1:0] p);
        return (p == POS_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_nxt      = f_adv(r_nwp);
    assign w_rd_nxt   = f_adv(r_nrp);
    assign w_full     = (w_nxt == r_crp) && (w_nxt == r_prp);
    assign w_empty    = (r_nrp == r_cwp) && (r_nrp == r_pwp);
    assign w_wr_ok    = i_ctl.exec && (r_cmd.op == OP_WRITE) && !w_full;
    assign w_rd_ok    = (r_cmd.op == OP_READ) && !w_empty;
    assign w_wcnt_inc = r_wcnt + 1'b1;
    assign w_rcnt_inc = r_rcnt + 1'b1;
    assign w_nb       = (r_cmd.write_bytes > NB_MAX) ? NB_MAX : r_cmd.write_bytes;
    assign o_sts.rd_hit = w_rd_ok;

    always_comb begin
        n_prp     = r_prp;
        n_pwp     = r_pwp;
        n_nrp     = r_nrp;
        n_nwp     = r_nwp;
        n_crp     = r_crp;
        n_cwp     = r_cwp;
        n_rcnt    = r_rcnt;
        n_wcnt    = r_wcnt;
        n_wrapped = r_wrapped;
        w_status  = ST_OK;
        case (t_op'(r_cmd.op))
            OP_WRITE: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    if (w_nxt == r_crp) n_crp = r_prp;
                    n_nwp = w_nxt;
                    if (r_nwp == POS_W'(DEPTH - 1)) n_wrapped = 1'b1;
                    if (w_wcnt_inc >= r_batch) begin
                        n_pwp  = w_nxt;
                        n_wcnt = '0;
                    end else begin
                        n_wcnt = w_wcnt_inc;
                    end
                end
            end
            OP_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    if (r_nrp == r_cwp) n_cwp = r_pwp;
                    n_nrp = w_rd_nxt;
                    if (w_rcnt_inc >= r_batch) begin
                        n_prp  = w_rd_nxt;
                        n_rcnt = '0;
                    end else begin
                        n_rcnt = w_rcnt_inc;
                    end
                end
            end
            OP_FLUSH: begin
                n_pwp = r_nwp;
                n_prp = r_nrp;
            end
            OP_RDONE: begin
                n_prp = r_nrp;
                n_crp = r_nrp;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        if (n_nwp < n_crp) begin
            w_occ = {1'b0, n_nwp} + (POS_W + 1)'(DEPTH) - {1'b0, n_crp};
        end else begin
            w_occ = {1'b0, n_nwp} - {1'b0, n_crp};
        end
    end

    // Until the write side wraps, the slot at the write position was never written:
    // write every lane then, with unused bytes zero, so reads see the cleared store.
    for (genvar i = 0; i < ENTRY_BYTES; i++) begin : g_lane
        logic w_sel;
        assign w_sel = (NB_W'(i) < w_nb);
        brb_ram #(
            .WIDTH (LANE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr_ok && (w_sel || !r_wrapped)),
            .i_waddr (r_nwp),
            .i_wdata (w_sel ? r_cmd.write_data[i*LANE_W +: LANE_W] : '0),
            .i_re    (i_ctl.exec && w_rd_ok),
            .i_raddr (r_nrp),
            .o_rdata (w_rdata[i*LANE_W +: LANE_W])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
        end
        if (i_ctl.exec) begin
            r_res.status    <= w_status;
            r_res.read_data <= '0;
            r_res.occupancy <= OCC_W'(w_occ);
        end
        if (i_ctl.capture_rd) begin
            r_res.read_data <= DATA_W'(w_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prp     <= '0;
            r_pwp     <= '0;
            r_nrp     <= '0;
            r_nwp     <= '0;
            r_crp     <= '0;
            r_cwp     <= '0;
            r_rcnt    <= '0;
            r_wcnt    <= '0;
            r_wrapped <= 1'b0;
            r_batch   <= LEN_W'(16);
            r_valid   <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                r_prp     <= n_prp;
                r_pwp     <= n_pwp;
                r_nrp     <= n_nrp;
                r_nwp     <= n_nwp;
                r_crp     <= n_crp;
                r_cwp     <= n_cwp;
                r_rcnt    <= n_rcnt;
                r_wcnt    <= n_wcnt;
                r_wrapped <= n_wrapped;
            end
            if (i_cfg_we) begin
                r_batch <= i_cfg_data;
            end
            r_valid <= i_ctl.finish;
        end
    end

    assign o_result = r_res;
    assign o_valid  = r_valid;

endmodule

`default_nettype wire

FILE: design/batched_spsc_ring_buffer.sv
// Top level of the batched SPSC ring buffer: controller plus datapath.
// Depends on brb_pkg, brb_ctrl, brb_datapath (and brb_ram through the datapath).
//
//  channel   direction  handshake               payload
//  command   in         start && !busy          i_cmd (t_in)
//  result    out        o_valid, one cycle      o_result (t_out)
//  config    in         i_cfg_we                i_cfg_data (batch_len)
//
// The result strobe is registered from the finish command that S_EXEC issues; a successful read
// strobes from S_RDWAIT, an extra state for the registered read of the entry store.
// The strobe appears while busy is already low, so the next transaction can be accepted
// at the edge ending it. Reset is synchronous; the store needs no clearing pass, since
// slots not yet reached by the first pass of the write side are written in full.
// Results cannot be stalled.
`default_nettype none

module batched_spsc_ring_buffer import brb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_in              i_cmd,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output t_out                  o_result
);

    t_cmd w_ctl;
    t_sts w_sts;

    brb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_ctl)
    );

    brb_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_result   (o_result),
        .o_valid    (o_valid)
    );

endmodule

`default_nettype wire

FILE: design/brb_checker.sv
// Port-level assertions for batched_spsc_ring_buffer, attached by bind.
// Depends on brb_pkg.
`default_nettype none

module brb_checker import brb_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire t_out o_result
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("not idle after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    a_strobe_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction in progress");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status != ST_OK) |-> (o_result.read_data == '0))
        else $error("refused transaction returned data");

endmodule

bind batched_spsc_ring_buffer brb_checker u_brb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
